[src/lltr_pkg.sv]
package lltr_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MEMBER_COUNT    = 2'd0;
  localparam logic [1:0] CFG_OCCUPANCY_LIMIT = 2'd1;
  localparam logic [1:0] CFG_HOLD_TIMEOUT    = 2'd2;
  localparam logic [1:0] CFG_IDLE_DELAY      = 2'd3;

  // Input word kinds (carried on tuser)
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam int unsigned OCC_W  = 16;
  localparam int unsigned STEP_W = 32;
  localparam int unsigned HIDX_W = 3;

  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  typedef logic [OCC_W-1:0]  occ_t;
  typedef logic [STEP_W-1:0] step_t;

  // Result word as packed into m_axis_tdata (lowest bit last)
  typedef struct packed {
    logic [1:0]        pad;
    logic              switched;
    logic              kill_request;
    logic [HIDX_W-1:0] holder_index;
    logic              holder_valid;
  } result_t;

endpackage

[src/least_loaded_token_rotator.sv]
// Token rotator: count words (tuser = 0) store one member's occupancy and are taken
// back to back, producing no output word. Tick words (tuser = 1) advance the saturating
// step counter and produce one result word each. A tick that needs no scan goes from
// acceptance through the check and output states to the result register; a tick that
// grants the token also runs the scan state between them, reading all n effective
// members. The grant time is set by the scan over the occupancy and release-step
// memories, which delivers one member per cycle through their single read port.
// A finished result waits in the output register while the next word is accepted.
module least_loaded_token_rotator
  import lltr_pkg::*;
#(
  parameter int unsigned MAX_MEMBERS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [2:0] member_index, [18:3] occupancy, zero pad
  input  logic        s_axis_tuser,   // [0] opcode
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] holder_valid, [3:1] holder_index,
                                      // [4] kill_request, [5] switched, zero pad
);

  localparam int unsigned IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_MEMBERS + 1);
  localparam int unsigned XW    = IDX_W + HIDX_W;
  localparam int unsigned NW    = CNT_W + 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_OUT
  } state_e;

  // config registers
  logic [3:0] cfg_member_count_q;
  occ_t       cfg_limit_q;
  occ_t       cfg_timeout_q;
  occ_t       cfg_delay_q;

  // state memories with per-entry valid bits (invalid reads as zero)
  occ_t                   occ_mem [MAX_MEMBERS];
  step_t                  rel_mem [MAX_MEMBERS];
  logic [MAX_MEMBERS-1:0] occ_vld_q;
  logic [MAX_MEMBERS-1:0] rel_vld_q;
  occ_t                   occ_rd_q;
  step_t                  rel_rd_q;
  logic                   occ_rv_q;
  logic                   rel_rv_q;

  // control state
  state_e          state_q;
  step_t           step_q;
  step_t           grant_start_q;
  step_t           delay_end_q;
  logic            delay_pending_q;
  logic            holder_present_q;
  logic [IDX_W-1:0] holder_q;
  logic            was_present_q;
  logic [IDX_W-1:0] was_holder_q;
  logic            kill_q;

  // scan state
  logic [CNT_W-1:0] scan_q;
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;
  logic             skip_q;
  logic [IDX_W-1:0] skip_idx_q;
  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  occ_t             best_occ_q;
  step_t            best_rel_q;

  logic    m_tvalid_q;
  result_t m_tdata_q;

  // combinational
  logic             s_acc;
  logic [HIDX_W-1:0] in_member_index;
  occ_t             in_occupancy;
  logic [XW-1:0]    in_idx_ext;
  logic             in_idx_ok;
  logic [IDX_W-1:0] in_addr;
  logic [NW-1:0]    mc_ext;
  logic [NW-1:0]    n_clamp;
  logic [CNT_W-1:0] n_active;
  logic [IDX_W-1:0] rd_addr;
  occ_t             occ_rd;
  step_t            rel_rd;
  step_t            step_inc;
  step_t            elapsed;
  logic             tmo_hit;
  logic             lim_hit;
  logic [STEP_W:0]  dly_sum;
  step_t            dly_end;
  logic             issue;
  logic             cand_ok;
  logic             better;
  logic             scan_done;
  logic             occ_we;
  logic             rel_we;
  logic             out_free;
  logic [XW-1:0]    holder_ext;
  logic [HIDX_W-1:0] holder_out;
  logic             switched;

  // input unpacking
  assign s_acc           = s_axis_tvalid && s_axis_tready;
  assign in_member_index = s_axis_tdata[2:0];
  assign in_occupancy    = s_axis_tdata[18:3];
  assign in_idx_ext      = XW'(in_member_index);
  assign in_idx_ok       = in_idx_ext < XW'(MAX_MEMBERS);
  assign in_addr         = in_idx_ext[IDX_W-1:0];

  // effective member count, clamped to [2, MAX_MEMBERS]
  assign mc_ext = NW'(cfg_member_count_q);
  always_comb begin
    priority if (mc_ext < NW'(2)) begin
      n_clamp = NW'(2);
    end else if (mc_ext > NW'(MAX_MEMBERS)) begin
      n_clamp = NW'(MAX_MEMBERS);
    end else begin
      n_clamp = mc_ext;
    end
  end
  assign n_active = n_clamp[CNT_W-1:0];

  // memory read port: scan address, else current holder
  assign rd_addr = (state_q == ST_SCAN) ? scan_q[IDX_W-1:0] : holder_q;
  assign occ_rd  = occ_rv_q ? occ_rd_q : '0;
  assign rel_rd  = rel_rv_q ? rel_rd_q : '0;

  // tick arithmetic
  assign step_inc = (step_q == STEP_MAX) ? step_q : step_q + STEP_W'(1);
  assign elapsed  = step_q - grant_start_q;
  assign tmo_hit  = (cfg_timeout_q != '0) && (elapsed >= STEP_W'(cfg_timeout_q));
  assign lim_hit  = (cfg_limit_q != '0) && (occ_rd >= cfg_limit_q);
  assign dly_sum  = {1'b0, step_q} + (STEP_W + 1)'(cfg_delay_q);
  assign dly_end  = dly_sum[STEP_W] ? STEP_MAX : dly_sum[STEP_W-1:0];

  // scan compare: less occupancy, then earlier release, then lower index
  assign issue     = scan_q < n_active;
  assign scan_done = !issue && !pend_q;
  assign cand_ok   = pend_q && !(skip_q && (pend_idx_q == skip_idx_q));
  assign better    = !found_q || (occ_rd < best_occ_q) ||
                     ((occ_rd == best_occ_q) && (rel_rd < best_rel_q));

  assign occ_we = (state_q == ST_IDLE) && s_acc && (s_axis_tuser == OP_COUNT) && in_idx_ok;
  assign rel_we = (state_q == ST_CHECK) && (step_q != STEP_W'(1)) &&
                  !(delay_pending_q && (step_q == delay_end_q)) &&
                  holder_present_q && (tmo_hit || lim_hit);

  assign out_free = !m_tvalid_q || m_axis_tready;

  // result fields
  assign holder_ext = XW'(holder_q);
  assign holder_out = holder_present_q ? holder_ext[HIDX_W-1:0] : '0;
  assign switched   = (holder_present_q != was_present_q) ||
                      (holder_present_q && (holder_q != was_holder_q));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_member_count_q <= 4'd2;
      cfg_limit_q        <= '0;
      cfg_timeout_q      <= '0;
      cfg_delay_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MEMBER_COUNT:    cfg_member_count_q <= cfg_wdata_i[3:0];
        CFG_OCCUPANCY_LIMIT: cfg_limit_q        <= cfg_wdata_i;
        CFG_HOLD_TIMEOUT:    cfg_timeout_q      <= cfg_wdata_i;
        CFG_IDLE_DELAY:      cfg_delay_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // occupancy memory
  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[in_addr] <= in_occupancy;
    end
    occ_rd_q <= occ_mem[rd_addr];
  end

  // release-step memory
  always_ff @(posedge clk_i) begin
    if (rel_we) begin
      rel_mem[holder_q] <= step_q;
    end
    rel_rd_q <= rel_mem[rd_addr];
  end

  // valid bits and registered read valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_vld_q <= '0;
      rel_vld_q <= '0;
      occ_rv_q  <= 1'b0;
      rel_rv_q  <= 1'b0;
    end else begin
      if (occ_we) begin
        occ_vld_q[in_addr] <= 1'b1;
      end
      if (rel_we) begin
        rel_vld_q[holder_q] <= 1'b1;
      end
      occ_rv_q <= occ_vld_q[rd_addr];
      rel_rv_q <= rel_vld_q[rd_addr];
    end
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      step_q           <= '0;
      grant_start_q    <= '0;
      delay_end_q      <= '0;
      delay_pending_q  <= 1'b0;
      holder_present_q <= 1'b0;
      holder_q         <= '0;
      was_present_q    <= 1'b0;
      was_holder_q     <= '0;
      kill_q           <= 1'b0;
      scan_q           <= '0;
      pend_q           <= 1'b0;
      pend_idx_q       <= '0;
      skip_q           <= 1'b0;
      skip_idx_q       <= '0;
      found_q          <= 1'b0;
      best_idx_q       <= '0;
      best_occ_q       <= '0;
      best_rel_q       <= '0;
      m_tvalid_q       <= 1'b0;
      m_tdata_q        <= '0;
    end else begin
      // output word leaves; a new one is loaded only from ST_OUT
      if (m_tvalid_q && m_axis_tready && (state_q != ST_OUT)) begin
        m_tvalid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_acc && (s_axis_tuser == OP_TICK)) begin
            step_q        <= step_inc;
            was_present_q <= holder_present_q;
            was_holder_q  <= holder_q;
            kill_q        <= 1'b0;
            state_q       <= ST_CHECK;
          end
        end

        // holder occupancy is on the read port now
        ST_CHECK: begin
          scan_q     <= '0;
          pend_q     <= 1'b0;
          found_q    <= 1'b0;
          skip_idx_q <= holder_q;
          priority if (step_q == STEP_W'(1)) begin
            skip_q  <= 1'b0;
            state_q <= ST_SCAN;
          end else if (delay_pending_q && (step_q == delay_end_q)) begin
            delay_pending_q <= 1'b0;
            skip_q          <= 1'b0;
            kill_q          <= 1'b1;
            state_q         <= ST_SCAN;
          end else if (holder_present_q && (tmo_hit || lim_hit)) begin
            if ((cfg_delay_q == '0) || tmo_hit) begin
              delay_pending_q <= 1'b0;
              skip_q          <= 1'b1;
              kill_q          <= !tmo_hit;
              state_q         <= ST_SCAN;
            end else begin
              delay_end_q      <= dly_end;
              delay_pending_q  <= 1'b1;
              holder_present_q <= 1'b0;
              holder_q         <= '0;
              state_q          <= ST_OUT;
            end
          end else begin
            state_q <= ST_OUT;
          end
        end

        // one member read per cycle, compared in the next cycle
        ST_SCAN: begin
          pend_q     <= issue;
          pend_idx_q <= scan_q[IDX_W-1:0];
          if (issue) begin
            scan_q <= scan_q + CNT_W'(1);
          end
          if (cand_ok && better) begin
            found_q    <= 1'b1;
            best_idx_q <= pend_idx_q;
            best_occ_q <= occ_rd;
            best_rel_q <= rel_rd;
          end
          if (scan_done) begin
            holder_q         <= best_idx_q;
            holder_present_q <= 1'b1;
            grant_start_q    <= step_q;
            state_q          <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (out_free) begin
            m_tvalid_q             <= 1'b1;
            m_tdata_q.pad          <= '0;
            m_tdata_q.switched     <= switched;
            m_tdata_q.kill_request <= kill_q;
            m_tdata_q.holder_index <= holder_out;
            m_tdata_q.holder_valid <= holder_present_q;
            state_q                <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // a pending delay means nobody holds the token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    delay_pending_q |-> !holder_present_q)
    else $error("delay pending while a holder is present");

  // a handover scan never lands on the member it excludes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && scan_done && skip_q) |->
      (found_q && (best_idx_q != skip_idx_q)))
    else $error("handover granted back to the released holder");

  // every accepted tick enters the decision state next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (s_axis_tuser == OP_TICK)) |=> (state_q == ST_CHECK))
    else $error("tick word not processed");

endmodule

[verif/token_grant_checker.sv]
// Watches the config port and both streams, keeps its own copy of the token
// rotation state and compares every output word with the predicted grant.
module token_grant_checker
  import lltr_pkg::*;
#(
  parameter int unsigned MAX_MEMBERS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [2:0] member_index, [18:3] occupancy, zero pad
  input  logic        s_axis_tuser,   // [0] opcode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [0] holder_valid, [3:1] holder_index,
                                      // [4] kill_request, [5] switched, zero pad
  output int          fail_count_o,
  output int          open_grants_o
);

  // Shadow configuration
  logic [3:0] members_cfg;
  occ_t       limit_cfg;
  occ_t       timeout_cfg;
  occ_t       delay_cfg;

  // Shadow rotation state
  occ_t              occ_mem  [MAX_MEMBERS];
  step_t             rel_step [MAX_MEMBERS];
  step_t             step_cnt;
  step_t             grant_at;
  step_t             delay_at;
  logic [HIDX_W-1:0] owner;
  logic              owner_on;
  logic              delay_armed;

  result_t expected_grants [$];
  int      fails = 0;

  function automatic void clear_state();
    members_cfg = 4'd2;
    limit_cfg   = '0;
    timeout_cfg = '0;
    delay_cfg   = '0;
    for (int i = 0; i < MAX_MEMBERS; i++) begin
      occ_mem[i]  = '0;
      rel_step[i] = '0;
    end
    step_cnt    = '0;
    grant_at    = '0;
    delay_at    = '0;
    owner       = '0;
    owner_on    = 1'b0;
    delay_armed = 1'b0;
    expected_grants.delete();
  endfunction

  // Least occupancy wins; ties go to the earliest release, then the lowest index
  function automatic void grant_token(logic skip_on, logic [HIDX_W-1:0] skip);
    int   n;
    int   best;
    logic found;
    n     = (members_cfg < 2) ? 2 : ((members_cfg > MAX_MEMBERS) ? MAX_MEMBERS : members_cfg);
    best  = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!(skip_on && i == skip)) begin
        if (!found) begin
          best  = i;
          found = 1'b1;
        end else if (occ_mem[i] < occ_mem[best] ||
                     (occ_mem[i] == occ_mem[best] && rel_step[i] < rel_step[best])) begin
          best = i;
        end
      end
    end
    owner    = best[HIDX_W-1:0];
    owner_on = 1'b1;
    grant_at = step_cnt;
  endfunction

  // Advance one tick and return the grant word it should produce
  function automatic result_t predict_grant();
    logic              was_on;
    logic [HIDX_W-1:0] was_owner;
    logic              kill;
    logic              move;
    logic              quick;
    logic [STEP_W:0]   sum;
    result_t           r;
    was_on    = owner_on;
    was_owner = owner;
    kill      = 1'b0;
    if (step_cnt != STEP_MAX) step_cnt++;
    if (step_cnt == 1) begin
      grant_token(1'b0, '0);
    end else if (delay_armed && step_cnt == delay_at) begin
      delay_armed = 1'b0;
      grant_token(1'b0, '0);
      kill = 1'b1;
    end else if (owner_on) begin
      move  = 1'b0;
      quick = 1'b0;
      if (timeout_cfg != 0 && (step_cnt - grant_at) >= timeout_cfg) begin
        move  = 1'b1;
        quick = 1'b1;
      end else if (limit_cfg != 0 && occ_mem[owner] >= limit_cfg) begin
        move = 1'b1;
      end
      if (move) begin
        rel_step[owner] = step_cnt;
        if (delay_cfg == 0 || quick) begin
          delay_armed = 1'b0;
          grant_token(1'b1, owner);
          kill = !quick;
        end else begin
          // nobody holds until the delay runs out; end step saturates
          sum         = {1'b0, step_cnt} + delay_cfg;
          delay_at    = sum[STEP_W] ? STEP_MAX : sum[STEP_W-1:0];
          delay_armed = 1'b1;
          owner_on    = 1'b0;
          owner       = '0;
        end
      end
    end
    r              = '0;
    r.holder_valid = owner_on;
    r.holder_index = owner_on ? owner : '0;
    r.kill_request = kill;
    r.switched     = (owner_on != was_on) || (owner_on && owner != was_owner);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got;
    result_t want;
    if (!rst_ni) begin
      clear_state();
    end else begin
      // config writes must come only while the block is idle; this model does not enforce it
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MEMBER_COUNT:    members_cfg = cfg_wdata_i[3:0];
          CFG_OCCUPANCY_LIMIT: limit_cfg   = cfg_wdata_i;
          CFG_HOLD_TIMEOUT:    timeout_cfg = cfg_wdata_i;
          CFG_IDLE_DELAY:      delay_cfg   = cfg_wdata_i;
          default: ;
        endcase
      end
      // output word against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected grant word, expected none, actual %h", $time, got);
          fails++;
        end else begin
          want = expected_grants.pop_front();
          check_field("holder_valid", want.holder_valid, got.holder_valid);
          check_field("holder_index", want.holder_index, got.holder_index);
          check_field("kill_request", want.kill_request, got.kill_request);
          check_field("switched", want.switched, got.switched);
        end
      end
      // input word: tick predicts a grant word, count updates occupancy
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_TICK) begin
          expected_grants.insert(expected_grants.size(), predict_grant());
        end else begin
          occ_mem[s_axis_tdata[2:0]] = s_axis_tdata[18:3];
        end
      end
    end
    open_grants_o <= expected_grants.size();
    fail_count_o  <= fails;
  end

endmodule

[verif/tb_least_loaded_token_rotator.sv]
module tb_least_loaded_token_rotator;
  import lltr_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [2:0] member_index, [18:3] occupancy, zero pad
  logic        s_axis_tuser;   // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] holder_valid, [3:1] holder_index,
                               // [4] kill_request, [5] switched, zero pad
  int          fail_count;
  int          open_grants;
  logic        calm;           // no idling on either side

  least_loaded_token_rotator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  token_grant_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .open_grants_o (open_grants)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver stalls about 13 percent of the time unless calm is set
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 13);
  end

  // Write all four registers, one per cycle
  task automatic set_config(input logic [3:0] members, input occ_t limit, input occ_t hold,
                            input occ_t delay);
    logic [11:0] junk;
    junk = 12'($urandom_range(0, 4095));
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MEMBER_COUNT;
    cfg_wdata_i <= {junk, members};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_OCCUPANCY_LIMIT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HOLD_TIMEOUT;
    cfg_wdata_i <= hold;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_IDLE_DELAY;
    cfg_wdata_i <= delay;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_word(input logic op, input logic [2:0] idx, input occ_t occ);
    if (!calm) begin
      while ($urandom_range(0, 99) < 13) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, occ, idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off until every grant word is back, then let the block settle
  task automatic wait_for_grants();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (open_grants != 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [3:0]  mc;
    occ_t        lim;
    occ_t        hold;
    occ_t        delay;
    occ_t        occ;
    logic [2:0]  idx;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_MEMBER_COUNT;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_COUNT;
    calm          <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First grant with a tie, limit handover with kill, then timeout handover
    set_config(4'd4, 16'd100, 16'd3, 16'd0);
    send_word(OP_COUNT, 3'd0, 16'd50);
    send_word(OP_COUNT, 3'd1, 16'd10);
    send_word(OP_COUNT, 3'd2, 16'd10);
    send_word(OP_COUNT, 3'd3, 16'hFFFF);
    send_word(OP_COUNT, 3'd7, 16'hFFFF);
    send_word(OP_TICK, 3'd0, 16'd0);
    send_word(OP_COUNT, 3'd1, 16'd100);
    send_word(OP_TICK, 3'd0, 16'd0);
    send_word(OP_COUNT, 3'd2, 16'd0);
    send_word(OP_TICK, 3'd0, 16'd0);
    send_word(OP_TICK, 3'd0, 16'd0);
    send_word(OP_TICK, 3'd0, 16'd0);
    wait_for_grants();

    // Member count above range, idle delay after the limit, then re-grant with kill
    set_config(4'd15, 16'hFFFF, 16'd0, 16'd2);
    send_word(OP_COUNT, 3'd0, 16'hFFFF);
    send_word(OP_TICK, 3'd0, 16'd0);
    send_word(OP_TICK, 3'd7, 16'hFFFF);
    send_word(OP_TICK, 3'd0, 16'd0);
    send_word(OP_TICK, 3'd0, 16'd0);
    wait_for_grants();

    // Eight phases of random words; the last one sets a long idle delay
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin mc = 4'd8;  lim = 16'd1;    hold = 16'd1;    delay = 16'd0;    end
        1: begin mc = 4'd0;  lim = 16'd20;   hold = 16'hFFFF; delay = 16'd1;    end
        2: begin mc = 4'd8;  lim = 16'd30;   hold = 16'd7;    delay = 16'd3;    end
        7: begin mc = 4'd1;  lim = 16'hFFFF; hold = 16'd5;    delay = 16'hFFFF; end
        default: begin
          mc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                             4'($urandom_range(2, 8));
          case ($urandom_range(0, 3))
            0:       lim = 16'd0;
            1:       lim = 16'hFFFF;
            default: lim = 16'($urandom_range(1, 40));
          endcase
          case ($urandom_range(0, 3))
            0:       hold = 16'd0;
            1:       hold = 16'($urandom_range(1, 3));
            default: hold = 16'($urandom_range(2, 12));
          endcase
          case ($urandom_range(0, 3))
            0:       delay = 16'd0;
            1:       delay = 16'd1;
            default: delay = 16'($urandom_range(2, 6));
          endcase
        end
      endcase
      set_config(mc, lim, hold, delay);
      calm <= (p == 2);
      for (int k = 0; k < 88; k++) begin
        idx = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
          0:       occ = 16'd0;
          1:       occ = 16'hFFFF;
          2:       occ = 16'($urandom_range(0, 65535));
          default: occ = (lim == 0 || lim > 1000) ? 16'($urandom_range(0, 60)) :
                         16'($urandom_range(0, lim + lim / 2 + 1));
        endcase
        if ($urandom_range(0, 99) < 55) send_word(OP_TICK, idx, occ);
        else send_word(OP_COUNT, idx, occ);
      end
      wait_for_grants();
      calm <= 1'b0;
    end

    if (fail_count == 0) begin
      $display("tb_least_loaded_token_rotator OK");
    end else begin
      $display("tb_least_loaded_token_rotator NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_least_loaded_token_rotator NOT OK");
    $finish;
  end

endmodule

[filelist.f]
src/lltr_pkg.sv
src/least_loaded_token_rotator.sv
verif/token_grant_checker.sv
verif/tb_least_loaded_token_rotator.sv
